[hw/rtl/bped_pkg.sv]
package bped_pkg;

  // Debounced press tracking per button
  typedef enum logic [1:0] {
    PS_IDLE  = 2'd0,
    PS_DOWN  = 2'd1,
    PS_UP    = 2'd2,
    PS_DWAIT = 2'd3
  } press_t;

  // What the last finished press left behind
  typedef enum logic [2:0] {
    PV_NONE  = 3'd0,
    PV_CLICK = 3'd1,
    PV_DWAIT = 3'd2,
    PV_LONG  = 3'd3,
    PV_CONT  = 3'd4
  } prev_t;

  // Event armed by the current press
  typedef enum logic [2:0] {
    PE_NONE   = 3'd0,
    PE_DOWN   = 3'd1,
    PE_LONG   = 3'd2,
    PE_DOUBLE = 3'd3,
    PE_CONT   = 3'd4
  } pend_t;

  // Reported event codes
  typedef enum logic [2:0] {
    EV_CLICK    = 3'd0,
    EV_DOUBLE   = 3'd1,
    EV_LONG     = 3'd2,
    EV_LONG_REL = 3'd3,
    EV_CONT     = 3'd4,
    EV_CONT_REL = 3'd5
  } ev_code_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_TRIGGER_LEVELS  = 3'd0,
    CFG_DEBOUNCE_TICKS  = 3'd1,
    CFG_LONG_TICKS      = 3'd2,
    CFG_REPEAT_TICKS    = 3'd3,
    CFG_DOUBLE_TICKS    = 3'd4,
    CFG_CONTINUOUS_MODE = 3'd5,
    CFG_LONG_ONCE_MODE  = 3'd6,
    CFG_CLICK_WAIT_MODE = 3'd7
  } cfg_idx_t;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [7:0]  HOLD_CAP   = 8'hFF;

  typedef struct packed {
    logic [7:0] trigger_levels;
    logic [7:0] debounce_ticks;
    logic [7:0] long_ticks;
    logic [7:0] repeat_ticks;
    logic [7:0] double_ticks;
    logic       continuous_mode;
    logic       long_once_mode;
    logic       click_wait_mode;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    trigger_levels:  8'hFF,
    debounce_ticks:  8'd2,
    long_ticks:      8'd50,
    repeat_ticks:    8'd1,
    double_ticks:    8'd15,
    continuous_mode: 1'b0,
    long_once_mode:  1'b0,
    click_wait_mode: 1'b1
  };

  // One button's state word as held in the state memory
  typedef struct packed {
    logic       stable_level;
    logic [7:0] debounce_count;
    press_t     press_state;
    prev_t      previous_state;
    pend_t      pending_event;
    logic [7:0] repeat_count;
    logic [7:0] hold_count;
    logic [7:0] gap_count;
  } entry_t;

  // Idle level is the inverse of the reset trigger mask, which is all ones
  localparam entry_t ENTRY_RESET = '{
    stable_level:   ~CFG_RESET.trigger_levels[0],
    debounce_count: 8'd0,
    press_state:    PS_IDLE,
    previous_state: PV_NONE,
    pending_event:  PE_NONE,
    repeat_count:   8'd0,
    hold_count:     8'd0,
    gap_count:      8'd0
  };

endpackage

[hw/rtl/bped_if.sv]
interface bped_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] button_index;
  logic       pin_level;

  modport source (output valid, output button_index, output pin_level, input ready);
  modport sink   (input valid, input button_index, input pin_level, output ready);
endinterface

interface bped_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_button;
  logic [2:0] event_code;

  modport source (output valid, output event_button, output event_code, input ready);
  modport sink   (input valid, input event_button, input event_code, output ready);
endinterface

[hw/rtl/bped_state_mem.sv]
module bped_state_mem #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output bped_pkg::entry_t                      rd_data,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  bped_pkg::entry_t                      wr_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  bped_pkg::entry_t mem [DEPTH];
  logic [DEPTH-1:0] valid_r;

  bped_pkg::entry_t mem_q_r;
  logic             rd_valid_r;
  logic [AW-1:0]    rd_addr_r;

  bped_pkg::entry_t fwd_data_r;
  logic [AW-1:0]    fwd_addr_r;
  logic             fwd_v_r;

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q_r    <= mem[rd_addr];
      rd_valid_r <= valid_r[rd_addr];
      rd_addr_r  <= rd_addr;
    end
  end

  // Write port, keep a copy of the newest write for forwarding
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
      fwd_data_r   <= wr_data;
      fwd_addr_r   <= wr_addr;
    end
  end

  // Entry valid bits and forward valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      fwd_v_r <= 1'b0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
      fwd_v_r          <= 1'b1;
    end
  end

  // Newest write to the same entry wins; an unwritten entry reads as reset
  always_comb begin
    if (fwd_v_r && (fwd_addr_r == rd_addr_r)) begin
      rd_data = fwd_data_r;
    end else if (rd_valid_r) begin
      rd_data = mem_q_r;
    end else begin
      rd_data = bped_pkg::ENTRY_RESET;
    end
  end

endmodule

[hw/rtl/bped_update.sv]
module bped_update (
  input  bped_pkg::entry_t   cur,
  input  logic               pin_level,
  input  logic               trig,
  input  bped_pkg::cfg_t     cfg,
  output bped_pkg::entry_t   nxt,
  output logic               ev_valid,
  output bped_pkg::ev_code_t ev_code
);

  always_comb begin
    nxt      = cur;
    ev_valid = 1'b0;
    ev_code  = bped_pkg::EV_CLICK;

    // Debounce: count differing ticks, accept the level at the threshold
    if (pin_level != nxt.stable_level) begin
      nxt.debounce_count = nxt.debounce_count + 8'd1;
      if (nxt.debounce_count >= cfg.debounce_ticks) begin
        nxt.stable_level   = pin_level;
        nxt.debounce_count = 8'd0;
        if (nxt.press_state == bped_pkg::PS_IDLE ||
            nxt.press_state == bped_pkg::PS_DWAIT) begin
          nxt.press_state = bped_pkg::PS_DOWN;
        end else if (nxt.press_state == bped_pkg::PS_DOWN) begin
          nxt.press_state = bped_pkg::PS_UP;
        end
      end
    end

    unique case (nxt.press_state)
      // Held: continuous repeat, or hold timing then long marking or long repeat
      bped_pkg::PS_DOWN: begin
        if (nxt.stable_level == trig) begin
          if (cfg.continuous_mode) begin
            nxt.repeat_count = nxt.repeat_count + 8'd1;
            if (nxt.repeat_count >= cfg.repeat_ticks) begin
              nxt.repeat_count  = 8'd0;
              nxt.pending_event = bped_pkg::PE_CONT;
              ev_valid          = 1'b1;
              ev_code           = bped_pkg::EV_CONT;
            end
          end else begin
            if (nxt.pending_event != bped_pkg::PE_LONG) begin
              nxt.pending_event = bped_pkg::PE_DOWN;
            end
            nxt.hold_count = nxt.hold_count + 8'd1;
            if (nxt.hold_count >= cfg.long_ticks) begin
              if (cfg.long_once_mode) begin
                nxt.pending_event = bped_pkg::PE_LONG;
              end else begin
                nxt.repeat_count = nxt.repeat_count + 8'd1;
                if (nxt.repeat_count >= cfg.repeat_ticks) begin
                  nxt.repeat_count  = 8'd0;
                  nxt.pending_event = bped_pkg::PE_LONG;
                  ev_valid          = 1'b1;
                  ev_code           = bped_pkg::EV_LONG;
                end
              end
              if (nxt.hold_count == bped_pkg::HOLD_CAP) begin
                nxt.hold_count = cfg.long_ticks;
              end
            end
          end
        end
      end
      // Released: resolve click, double, long or continuous release
      bped_pkg::PS_UP: begin
        if (nxt.pending_event == bped_pkg::PE_DOWN) begin
          if (nxt.gap_count <= cfg.double_ticks &&
              nxt.previous_state == bped_pkg::PV_DWAIT) begin
            nxt.pending_event  = bped_pkg::PE_DOUBLE;
            ev_valid           = 1'b1;
            ev_code            = bped_pkg::EV_DOUBLE;
            nxt.press_state    = bped_pkg::PS_IDLE;
            nxt.previous_state = bped_pkg::PV_NONE;
          end else begin
            nxt.gap_count  = 8'd0;
            nxt.hold_count = 8'd0;
            if (!cfg.click_wait_mode) begin
              ev_valid = 1'b1;
              ev_code  = bped_pkg::EV_CLICK;
            end
            nxt.press_state    = bped_pkg::PS_DWAIT;
            nxt.previous_state = bped_pkg::PV_DWAIT;
          end
        end else if (nxt.pending_event == bped_pkg::PE_LONG) begin
          ev_valid           = 1'b1;
          ev_code            = cfg.long_once_mode ? bped_pkg::EV_LONG
                                                  : bped_pkg::EV_LONG_REL;
          nxt.hold_count     = 8'd0;
          nxt.press_state    = bped_pkg::PS_IDLE;
          nxt.previous_state = bped_pkg::PV_LONG;
          nxt.pending_event  = bped_pkg::PE_DOWN;
        end else if (cfg.continuous_mode &&
                     nxt.pending_event == bped_pkg::PE_CONT) begin
          nxt.hold_count     = 8'd0;
          ev_valid           = 1'b1;
          ev_code            = bped_pkg::EV_CONT_REL;
          nxt.press_state    = bped_pkg::PS_IDLE;
          nxt.previous_state = bped_pkg::PV_CONT;
        end
      end
      // Waiting for a second press: time out the double window
      bped_pkg::PS_DWAIT: begin
        nxt.gap_count = nxt.gap_count + 8'd1;
        if (nxt.gap_count >= cfg.double_ticks) begin
          nxt.press_state    = bped_pkg::PS_IDLE;
          nxt.previous_state = bped_pkg::PV_NONE;
          if (cfg.click_wait_mode) begin
            nxt.gap_count      = 8'd0;
            ev_valid           = 1'b1;
            ev_code            = bped_pkg::EV_CLICK;
            nxt.previous_state = bped_pkg::PV_CLICK;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[hw/rtl/button_press_event_detector.sv]
// Button press event detector. Each input beat is one tick sample of one
// button (button number and raw pin level); the block debounces it and
// reports click, double click, long press, long release, continuous repeat
// and continuous release, at most one result beat per input beat. It takes
// one beat per cycle while the output is not stalled: the button's state
// word is read from a synchronous state memory when the beat is accepted,
// updated in the update stage and written back as that stage advances, with
// the newest write forwarded so that beats for the same button may follow
// each other directly. A result waits in the output register until taken.
// Beats whose button number is not below NUM_BUTTONS are taken and dropped.
// All state resets at once: valid bits make unwritten entries read as the
// idle state. Configuration writes take effect on the next cycle and should
// be made while no beat is in flight.
module button_press_event_detector #(
  parameter int unsigned NUM_BUTTONS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  bped_in_if.sink                             in_chan,
  bped_out_if.source                          out_chan,
  input  logic                                cfg_we,
  input  logic [bped_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bped_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int unsigned AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  bped_pkg::cfg_t     cfg_r;
  bped_pkg::entry_t   rd_entry;
  bped_pkg::entry_t   upd_entry;
  logic               upd_ev_valid;
  bped_pkg::ev_code_t upd_ev_code;

  logic       s1_v_r;
  logic       s1_v_nxt;
  logic [2:0] s1_button_r;
  logic       s1_level_r;
  logic       s1_fire;
  logic       in_take;
  logic       in_range;

  logic               out_v_r;
  logic               out_v_nxt;
  logic [2:0]         out_button_r;
  bped_pkg::ev_code_t out_code_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= bped_pkg::CFG_RESET;
    end else if (cfg_we) begin
      unique case (bped_pkg::cfg_idx_t'(cfg_index))
        bped_pkg::CFG_TRIGGER_LEVELS:  cfg_r.trigger_levels  <= cfg_wdata;
        bped_pkg::CFG_DEBOUNCE_TICKS:  cfg_r.debounce_ticks  <= cfg_wdata;
        bped_pkg::CFG_LONG_TICKS:      cfg_r.long_ticks      <= cfg_wdata;
        bped_pkg::CFG_REPEAT_TICKS:    cfg_r.repeat_ticks    <= cfg_wdata;
        bped_pkg::CFG_DOUBLE_TICKS:    cfg_r.double_ticks    <= cfg_wdata;
        bped_pkg::CFG_CONTINUOUS_MODE: cfg_r.continuous_mode <= cfg_wdata[0];
        bped_pkg::CFG_LONG_ONCE_MODE:  cfg_r.long_once_mode  <= cfg_wdata[0];
        bped_pkg::CFG_CLICK_WAIT_MODE: cfg_r.click_wait_mode <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // Handshake: advance the update stage unless its result has nowhere to go
  assign s1_fire       = s1_v_r && (!upd_ev_valid || !out_v_r || out_chan.ready);
  assign in_chan.ready = !s1_v_r || s1_fire;
  assign in_take       = in_chan.valid && in_chan.ready;
  assign in_range      = int'(in_chan.button_index) < int'(NUM_BUTTONS);

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_take && in_range) begin
      s1_v_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  // Hold the sample while its state word is read
  always_ff @(posedge clk) begin
    if (in_take && in_range) begin
      s1_button_r <= in_chan.button_index;
      s1_level_r  <= in_chan.pin_level;
    end
  end

  bped_state_mem #(
    .DEPTH (NUM_BUTTONS)
  ) u_state_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_take && in_range),
    .rd_addr (AW'(in_chan.button_index)),
    .rd_data (rd_entry),
    .wr_en   (s1_fire),
    .wr_addr (AW'(s1_button_r)),
    .wr_data (upd_entry)
  );

  bped_update u_update (
    .cur       (rd_entry),
    .pin_level (s1_level_r),
    .trig      (cfg_r.trigger_levels[s1_button_r]),
    .cfg       (cfg_r),
    .nxt       (upd_entry),
    .ev_valid  (upd_ev_valid),
    .ev_code   (upd_ev_code)
  );

  // Output register: load a new event beat, drop it once taken
  always_comb begin
    out_v_nxt = out_v_r;
    if (s1_fire && upd_ev_valid) begin
      out_v_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && upd_ev_valid) begin
      out_button_r <= s1_button_r;
      out_code_r   <= upd_ev_code;
    end
  end

  assign out_chan.valid        = out_v_r;
  assign out_chan.event_button = out_button_r;
  assign out_chan.event_code   = out_code_r;

endmodule
